>>> rtl/q2rm_pkg.sv
`default_nettype none
package q2rm_pkg;

  // Field format
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // Matrix entries carried through the divider
  localparam int LANES = 9;

  // Internal widths: products, norm, numerators
  localparam int PW   = 2 * DATA_WIDTH;
  localparam int NW   = 2 * DATA_WIDTH + 1;
  localparam int NUMW = 2 * DATA_WIDTH + 2;

  // Divider: fraction bits plus one rounding bit, a few bits per stage
  localparam int DIV_STEPS       = FRAC_BITS + 1;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int QW              = FRAC_BITS + 2;
  localparam int CW              = QW + DATA_WIDTH;

  // Saturation limit: +1.0, or the largest positive code if +1.0 does not fit
  localparam longint ONE_VAL = longint'(64'd1 << FRAC_BITS);
  localparam longint MAX_POS = longint'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [DATA_WIDTH-1:0] ENTRY_LIM =
    (ONE_VAL > MAX_POS) ? DATA_WIDTH'(MAX_POS) : DATA_WIDTH'(ONE_VAL);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
  } quat_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic                         zero_norm;
  } rot_out_t;

  // One entry in flight through the divider
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
  } lane_t;

endpackage
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, signed Q2.14 in and out.
//
// Input channel in_valid / in_stall / in_data carries one quaternion (x, y, z, w).
// Output channel out_valid / out_stall / out_data carries the nine matrix entries
// of the normalised quaternion and a zero_norm flag. A request is taken at a
// rising edge with valid high and stall low.
//
// Pipeline from accept to out_valid: products, norm and numerators, magnitude,
// integer step, five divider stages of three quotient bits each, then rounding
// and saturation.
// Throughput: one request per clock; every stage is registered, so only a
// stalled result slows intake.
//
// An all-zero quaternion gives the identity matrix with zero_norm set.
// Entries are rounded to nearest (halves away from zero) and saturated to +/-1.0.
//
// Reset (rst_n low, synchronous) empties the pipeline. While out_valid is high
// and out_stall is asserted the whole pipeline holds and in_stall is raised;
// nothing is dropped or repeated.
`default_nettype none
module quaternion_to_rotation_matrix (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire q2rm_pkg::quat_in_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output q2rm_pkg::rot_out_t      out_data
);
  import q2rm_pkg::*;

  logic en;

  // Stage A: squares and cross products
  logic                 a_vld_r;
  logic                 a_zero_r;
  logic signed [PW-1:0] a_sq_r [4];
  logic signed [PW-1:0] a_cr_r [6];
  logic signed [PW-1:0] a_sq_nxt [4];
  logic signed [PW-1:0] a_cr_nxt [6];

  // Stage B: norm and signed numerators
  logic                   b_vld_r;
  logic                   b_zero_r;
  logic [NW-1:0]          b_n_r;
  logic signed [NUMW-1:0] b_num_r [LANES];
  logic [NW-1:0]          b_n_nxt;
  logic signed [NUMW-1:0] b_num_nxt [LANES];

  // Stage C: sign and magnitude
  logic          c_vld_r;
  logic          c_zero_r;
  logic [NW-1:0] c_n_r;
  logic          c_neg_r [LANES];
  logic [NW-1:0] c_mag_r [LANES];

  // Divider stages: index 0 holds the integer step
  logic [DIV_STAGES:0] d_vld_r;
  logic                d_zero_r [DIV_STAGES+1];
  logic [NW-1:0]       d_n_r    [DIV_STAGES+1];
  lane_t               d_lane_r [DIV_STAGES+1][LANES];
  lane_t               d_lane_nxt [DIV_STAGES+1][LANES];

  // Output register
  logic                  out_vld_r;
  rot_out_t              out_r;
  rot_out_t              out_nxt;
  logic [DATA_WIDTH-1:0] ent [LANES];

  // Global advance: hold everything while a finished result is stalled
  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  // Several restoring division steps on one entry
  function automatic lane_t div_stage(lane_t li, logic [NW-1:0] n, int stg);
    lane_t       lo;
    logic [NW:0] r2;
    lo = li;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      if (stg * STEPS_PER_STAGE + j < DIV_STEPS) begin
        r2 = {lo.rem, 1'b0};
        if (r2 >= {1'b0, n}) begin
          lo.rem = NW'(r2 - {1'b0, n});
          lo.quo = {lo.quo[QW-2:0], 1'b1};
        end else begin
          lo.rem = r2[NW-1:0];
          lo.quo = {lo.quo[QW-2:0], 1'b0};
        end
      end
    end
    return lo;
  endfunction

  // Products; signed operands widen to the product width
  always_comb begin
    a_sq_nxt[0] = PW'(in_data.quat_x) * PW'(in_data.quat_x);
    a_sq_nxt[1] = PW'(in_data.quat_y) * PW'(in_data.quat_y);
    a_sq_nxt[2] = PW'(in_data.quat_z) * PW'(in_data.quat_z);
    a_sq_nxt[3] = PW'(in_data.quat_w) * PW'(in_data.quat_w);
    a_cr_nxt[0] = PW'(in_data.quat_x) * PW'(in_data.quat_y);
    a_cr_nxt[1] = PW'(in_data.quat_x) * PW'(in_data.quat_z);
    a_cr_nxt[2] = PW'(in_data.quat_y) * PW'(in_data.quat_z);
    a_cr_nxt[3] = PW'(in_data.quat_w) * PW'(in_data.quat_x);
    a_cr_nxt[4] = PW'(in_data.quat_w) * PW'(in_data.quat_y);
    a_cr_nxt[5] = PW'(in_data.quat_w) * PW'(in_data.quat_z);
  end

  // Norm, diagonal numerators (c^2 + w^2) - (a^2 + b^2), off-diagonals 2(pq +/- wr)
  always_comb begin
    logic signed [NUMW-1:0] sx, sy, sz, sw;
    logic signed [NUMW-1:0] xy, xz, yz, wx, wy, wz;
    sx = NUMW'(a_sq_r[0]);
    sy = NUMW'(a_sq_r[1]);
    sz = NUMW'(a_sq_r[2]);
    sw = NUMW'(a_sq_r[3]);
    xy = NUMW'(a_cr_r[0]);
    xz = NUMW'(a_cr_r[1]);
    yz = NUMW'(a_cr_r[2]);
    wx = NUMW'(a_cr_r[3]);
    wy = NUMW'(a_cr_r[4]);
    wz = NUMW'(a_cr_r[5]);
    b_n_nxt = NW'($unsigned(a_sq_r[0])) + NW'($unsigned(a_sq_r[1]))
            + NW'($unsigned(a_sq_r[2])) + NW'($unsigned(a_sq_r[3]));
    b_num_nxt[0] = (sx + sw) - (sy + sz);
    b_num_nxt[1] = (xy + wz) <<< 1;
    b_num_nxt[2] = (xz - wy) <<< 1;
    b_num_nxt[3] = (xy - wz) <<< 1;
    b_num_nxt[4] = (sy + sw) - (sx + sz);
    b_num_nxt[5] = (yz + wx) <<< 1;
    b_num_nxt[6] = (xz + wy) <<< 1;
    b_num_nxt[7] = (yz - wx) <<< 1;
    b_num_nxt[8] = (sz + sw) - (sx + sy);
  end

  // Integer quotient bit and the later fraction stages
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      d_lane_nxt[0][l].neg = c_neg_r[l];
      if (c_mag_r[l] >= c_n_r) begin
        d_lane_nxt[0][l].rem = NW'(c_mag_r[l] - c_n_r);
        d_lane_nxt[0][l].quo = QW'(1);
        d_lane_nxt[0][l].ovf = ({1'b0, c_mag_r[l]} >= {c_n_r, 1'b0});
      end else begin
        d_lane_nxt[0][l].rem = c_mag_r[l];
        d_lane_nxt[0][l].quo = '0;
        d_lane_nxt[0][l].ovf = 1'b0;
      end
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        d_lane_nxt[k][l] = div_stage(d_lane_r[k-1][l], d_n_r[k-1], k - 1);
      end
    end
  end

  // Round, saturate, apply sign; zero norm forces identity
  always_comb begin
    logic [QW-1:0]         vq;
    logic [DATA_WIDTH-1:0] mag;
    for (int l = 0; l < LANES; l++) begin
      vq  = {1'b0, d_lane_r[DIV_STAGES][l].quo[QW-1:1]}
          + QW'(d_lane_r[DIV_STAGES][l].quo[0]);
      if (d_lane_r[DIV_STAGES][l].ovf || (CW'(vq) > CW'(ENTRY_LIM))) begin
        mag = ENTRY_LIM;
      end else begin
        mag = DATA_WIDTH'(vq);
      end
      ent[l] = d_lane_r[DIV_STAGES][l].neg ? DATA_WIDTH'(-mag) : mag;
      if (d_zero_r[DIV_STAGES]) begin
        ent[l] = (l == 0 || l == 4 || l == 8) ? ENTRY_LIM : '0;
      end
    end
    out_nxt.m00       = ent[0];
    out_nxt.m01       = ent[1];
    out_nxt.m02       = ent[2];
    out_nxt.m10       = ent[3];
    out_nxt.m11       = ent[4];
    out_nxt.m12       = ent[5];
    out_nxt.m20       = ent[6];
    out_nxt.m21       = ent[7];
    out_nxt.m22       = ent[8];
    out_nxt.zero_norm = d_zero_r[DIV_STAGES];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_valid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= {d_vld_r[DIV_STAGES-1:0], c_vld_r};
      out_vld_r <= d_vld_r[DIV_STAGES];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_zero_r <= (in_data.quat_x == '0) && (in_data.quat_y == '0)
               && (in_data.quat_z == '0) && (in_data.quat_w == '0);
      a_sq_r   <= a_sq_nxt;
      a_cr_r   <= a_cr_nxt;
      b_zero_r <= a_zero_r;
      b_n_r    <= b_n_nxt;
      b_num_r  <= b_num_nxt;
      c_zero_r <= b_zero_r;
      c_n_r    <= b_n_r;
      for (int l = 0; l < LANES; l++) begin
        c_neg_r[l] <= b_num_r[l][NUMW-1];
        c_mag_r[l] <= b_num_r[l][NUMW-1] ? NW'(-b_num_r[l]) : NW'(b_num_r[l]);
      end
      d_zero_r[0] <= c_zero_r;
      d_n_r[0]    <= c_n_r;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        d_zero_r[k] <= d_zero_r[k-1];
        d_n_r[k]    <= d_n_r[k-1];
      end
      d_lane_r <= d_lane_nxt;
      out_r    <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> rtl/q2rm_checker.sv
`default_nettype none
module q2rm_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_stall,
  input wire                     out_valid,
  input wire                     out_stall,
  input wire q2rm_pkg::rot_out_t out_data
);
  import q2rm_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A blocked output stops intake
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // Zero norm gives the identity
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |->
      out_data.m00 == ENTRY_LIM && out_data.m11 == ENTRY_LIM &&
      out_data.m22 == ENTRY_LIM && out_data.m01 == '0 && out_data.m02 == '0 &&
      out_data.m10 == '0 && out_data.m12 == '0 && out_data.m20 == '0 &&
      out_data.m21 == '0)
    else $error("zero norm result is not identity");

  // m00 stays within +/-1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_data.m00) <= $signed(ENTRY_LIM) &&
                  $signed(out_data.m00) >= -$signed(ENTRY_LIM))
    else $error("m00 out of range");

endmodule

bind quaternion_to_rotation_matrix q2rm_checker u_q2rm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
